// ===== rtl/core/rc_pkg.sv =====
// Package for the radix converter: widths, error codes and the digit glyph function.
`default_nettype none

package rc_pkg;

    // Field and register widths
    localparam int SRC_W    = 30;
    localparam int CHAR_W   = 7;
    localparam int ERR_W    = 2;
    localparam int SB_W     = 4;
    localparam int TB_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 6;

    // Parameter defaults
    localparam int SRC_DIGITS_DEF     = 9;
    localparam int MAX_OUT_DIGITS_DEF = 30;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = 1'd1;

    // Register reset values and legal ranges
    localparam logic [SB_W-1:0] SB_RESET = 4'd10;
    localparam logic [SB_W-1:0] SB_MIN   = 4'd2;
    localparam logic [SB_W-1:0] SB_MAX   = 4'd10;
    localparam logic [TB_W-1:0] TB_RESET = 6'd2;
    localparam logic [TB_W-1:0] TB_MIN   = 6'd2;
    localparam logic [TB_W-1:0] TB_MAX   = 6'd36;

    // Radix of the input digit positions
    localparam logic [TB_W-1:0] DEC_RADIX = 6'd10;

    // Reciprocal of ten: (n * DEC_RECIP) >> DEC_SHIFT is n / 10 for any SRC_W-bit n
    localparam logic [SRC_W-1:0] DEC_RECIP = 30'h3333_3334;
    localparam int               DEC_SHIFT = 33;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_ZERO  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DIGIT = 2'd2;

    // ASCII offsets: '0' for digits, 'A' - 10 for letters
    localparam logic [CHAR_W-1:0] CHAR_NUM_BASE   = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 7'h37;

    typedef logic [CHAR_W-1:0] char_t;

    // Map a digit value 0..35 onto '0'-'9', 'A'-'Z'
    function automatic char_t digit_glyph(input logic [TB_W-1:0] d);
        char_t ch;
        if (d < 6'd10)
            ch = CHAR_NUM_BASE + {1'b0, d};
        else
            ch = CHAR_ALPHA_BASE + {1'b0, d};
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rc_if.sv =====
// Valid/ready channel interfaces for the radix converter input and output.
`default_nettype none

interface rc_in_if;
    logic                      valid;
    logic                      ready;
    logic [rc_pkg::SRC_W-1:0]  src_number;

    modport source (output valid, output src_number, input ready);
    modport sink   (input valid, input src_number, output ready);
endinterface

interface rc_out_if;
    logic                      valid;
    logic                      ready;
    logic [rc_pkg::CHAR_W-1:0] digit_char;
    logic                      last;
    logic [rc_pkg::ERR_W-1:0]  error;

    modport source (output valid, output digit_char, output last, output error, input ready);
    modport sink   (input valid, input digit_char, input last, input error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/radix_converter.sv =====
// Radix converter top level: digit check, weighting, repeated division and character output.
//
// Each input transaction is a number whose decimal positions hold digits of the source
// base; the block checks the digits, builds the binary value and emits it in the target
// base as ASCII characters, most significant first, with last set on the final one.
// A zero input or a bad digit yields a single transaction with digit_char 0, last 1 and
// the error code. Decimal positions are peeled off by a reciprocal multiplication by one
// tenth, through states S_DDIV, S_DREM and S_DACC for each position. Divisions by the
// target base run on one shared bit-serial restoring divider in S_CDIV, with each
// remainder stored in S_CSTO, and each character waits for a free output register.
// A bad digit ends the item at the first failing position, and a zero input goes
// straight to the error transaction. src.ready is high only while the sequencer is idle;
// the output register lets the next item be taken while the final character still waits
// on dst.ready.
`default_nettype none

module radix_converter #(
    parameter int SRC_DIGITS     = rc_pkg::SRC_DIGITS_DEF,
    parameter int MAX_OUT_DIGITS = rc_pkg::MAX_OUT_DIGITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rc_pkg::CFG_W-1:0]      cfg_data,
    rc_in_if.sink                              src,
    rc_out_if.source                           dst
);
    import rc_pkg::*;

    localparam int POS_W   = $clog2(SRC_DIGITS + 1);
    localparam int CNT_W   = $clog2(MAX_OUT_DIGITS + 1);
    localparam int IDX_W   = (MAX_OUT_DIGITS > 1) ? $clog2(MAX_OUT_DIGITS) : 1;
    localparam int STEP_W  = $clog2(SRC_W);
    localparam logic [POS_W-1:0]  POS_LIMIT = POS_W'(SRC_DIGITS);
    localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(MAX_OUT_DIGITS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SRC_W - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DDIV = 3'd1;
    localparam logic [2:0] S_DACC = 3'd2;
    localparam logic [2:0] S_CDIV = 3'd3;
    localparam logic [2:0] S_CSTO = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;
    localparam logic [2:0] S_ERR  = 3'd6;
    localparam logic [2:0] S_DREM = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [SB_W-1:0]   sb_reg;
    logic [TB_W-1:0]   tb_reg;
    logic [SB_W-1:0]   sb_eff;
    logic [TB_W-1:0]   tb_eff;

    // Shared divider
    logic [SRC_W-1:0]  div_q_reg, div_q_next;
    logic [TB_W-1:0]   div_r_reg, div_r_next;
    logic [TB_W-1:0]   divisor_reg, divisor_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TB_W:0]     rem_shift;
    logic              rem_ge;
    logic [TB_W:0]     rem_sub;
    logic [SRC_W-1:0]  q_step;
    logic [TB_W-1:0]   r_step;

    // Division by ten
    logic [2*SRC_W-1:0] dec_prod;
    logic [SRC_W-1:0]   dec_q_reg, dec_q_next;
    logic [SRC_W-1:0]   dec_rem;

    // Weighting
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SRC_W-1:0]  acc_reg, acc_next;
    logic [SRC_W-1:0]  weight_reg, weight_next;
    logic [SRC_W+SB_W-1:0] digit_prod;
    logic [SRC_W+SB_W-1:0] weight_prod;
    logic [SRC_W-1:0]  acc_sum;

    // Target digits
    logic [TB_W-1:0]   store_mem [MAX_OUT_DIGITS];
    logic              store_we;
    logic [CNT_W-1:0]  ocnt_reg, ocnt_next;
    logic [CNT_W-1:0]  ocnt_inc;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ERR_W-1:0]  err_reg, err_next;

    // Output register
    logic              ov_reg, ov_next;
    logic [CHAR_W-1:0] ochar_reg, ochar_next;
    logic              olast_reg, olast_next;
    logic [ERR_W-1:0]  oerr_reg, oerr_next;
    logic              out_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_reg <= SB_RESET;
            tb_reg <= TB_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_BASE: sb_reg <= cfg_data[SB_W-1:0];
                REG_TARGET_BASE: tb_reg <= cfg_data[TB_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp bases into their legal ranges
    assign sb_eff = (sb_reg < SB_MIN) ? SB_MIN : ((sb_reg > SB_MAX) ? SB_MAX : sb_reg);
    assign tb_eff = (tb_reg < TB_MIN) ? TB_MIN : ((tb_reg > TB_MAX) ? TB_MAX : tb_reg);

    // One restoring division step
    assign rem_shift = {div_r_reg, div_q_reg[SRC_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor_reg};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};
    assign r_step    = rem_ge ? rem_sub[TB_W-1:0] : rem_shift[TB_W-1:0];
    assign q_step    = {div_q_reg[SRC_W-2:0], rem_ge};

    // Quotient by ten from the reciprocal, remainder from the registered quotient
    assign dec_prod = div_q_reg * DEC_RECIP;
    assign dec_rem  = div_q_reg - dec_q_reg * SRC_W'(DEC_RADIX);

    // Digit weighting; remainder of a division by ten fits in SB_W bits
    assign digit_prod  = div_r_reg[SB_W-1:0] * weight_reg;
    assign weight_prod = weight_reg * sb_eff;
    assign acc_sum     = acc_reg + digit_prod[SRC_W-1:0];

    assign ocnt_inc = (ocnt_reg < CNT_LIMIT) ? ocnt_reg + 1'b1 : ocnt_reg;
    assign out_free = !ov_reg || dst.ready;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        div_q_next   = div_q_reg;
        div_r_next   = div_r_reg;
        divisor_next = divisor_reg;
        step_next    = step_reg;
        dec_q_next   = dec_q_reg;
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        weight_next  = weight_reg;
        ocnt_next    = ocnt_reg;
        idx_next     = idx_reg;
        err_next     = err_reg;
        store_we     = 1'b0;
        ov_next      = (ov_reg && dst.ready) ? 1'b0 : ov_reg;
        ochar_next   = ochar_reg;
        olast_next   = olast_reg;
        oerr_next    = oerr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (src.valid)
                begin
                    if (src.src_number == '0)
                    begin
                        err_next   = ERR_ZERO;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        div_q_next   = src.src_number;
                        div_r_next   = '0;
                        step_next    = '0;
                        pos_next     = '0;
                        acc_next     = '0;
                        weight_next  = SRC_W'(1);
                        state_next   = S_DDIV;
                    end
                end
            end
            S_DDIV:
            begin
                dec_q_next = SRC_W'(dec_prod[2*SRC_W-1:DEC_SHIFT]);
                state_next = S_DREM;
            end
            S_DREM:
            begin
                div_r_next = dec_rem[TB_W-1:0];
                div_q_next = dec_q_reg;
                state_next = S_DACC;
            end
            S_CDIV:
            begin
                div_q_next = q_step;
                div_r_next = r_step;
                step_next  = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = S_CSTO;
            end
            S_DACC:
            begin
                if (pos_reg >= POS_LIMIT || div_r_reg >= {2'b00, sb_eff})
                begin
                    err_next   = ERR_DIGIT;
                    state_next = S_ERR;
                end
                else
                begin
                    acc_next    = acc_sum;
                    weight_next = weight_prod[SRC_W-1:0];
                    pos_next    = pos_reg + 1'b1;
                    div_r_next  = '0;
                    step_next   = '0;
                    if (div_q_reg == '0)
                    begin
                        div_q_next   = acc_sum;
                        divisor_next = tb_eff;
                        ocnt_next    = '0;
                        state_next   = S_CDIV;
                    end
                    else
                    begin
                        state_next = S_DDIV;
                    end
                end
            end
            S_CSTO:
            begin
                store_we  = ocnt_reg < CNT_LIMIT;
                ocnt_next = ocnt_inc;
                if (div_q_reg == '0)
                begin
                    idx_next   = IDX_W'(ocnt_inc - 1'b1);
                    state_next = S_EMIT;
                end
                else
                begin
                    div_r_next = '0;
                    step_next  = '0;
                    state_next = S_CDIV;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ochar_next = digit_glyph(store_mem[idx_reg]);
                    olast_next = idx_reg == '0;
                    oerr_next  = ERR_OK;
                    if (idx_reg == '0)
                        state_next = S_IDLE;
                    else
                        idx_next = idx_reg - 1'b1;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ochar_next = '0;
                    olast_next = 1'b1;
                    oerr_next  = err_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            step_reg  <= '0;
            pos_reg   <= '0;
            ocnt_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            step_reg  <= step_next;
            pos_reg   <= pos_next;
            ocnt_reg  <= ocnt_next;
            idx_reg   <= idx_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        div_q_reg   <= div_q_next;
        div_r_reg   <= div_r_next;
        divisor_reg <= divisor_next;
        dec_q_reg   <= dec_q_next;
        acc_reg     <= acc_next;
        weight_reg  <= weight_next;
        err_reg     <= err_next;
        ochar_reg   <= ochar_next;
        olast_reg   <= olast_next;
        oerr_reg    <= oerr_next;
    end

    // Target digit store, least significant first
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[ocnt_reg[IDX_W-1:0]] <= div_r_reg;
    end

    assign src.ready      = state_reg == S_IDLE;
    assign dst.valid      = ov_reg;
    assign dst.digit_char = ochar_reg;
    assign dst.last       = olast_reg;
    assign dst.error      = oerr_reg;

    // Error transactions carry no character and close the item
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (dst.valid && dst.error != ERR_OK) |-> (dst.digit_char == '0 && dst.last))
        else $error("error transaction with character or without last");

    // Divider remainder stays below the divisor while dividing
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CDIV) |-> (div_r_reg < divisor_reg))
        else $error("divider remainder not below divisor");

    // Emit index stays inside the stored digits
    a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> ({1'b0, idx_reg} < {1'b0, ocnt_reg}))
        else $error("emit index beyond stored digit count");

    // An accepted input always starts work
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (src.valid && src.ready) |=> (state_reg != S_IDLE))
        else $error("accepted input left the sequencer idle");

endmodule

`default_nettype wire

// ===== tb/radix_converter_tb.sv =====
// Testbench for the radix converter: directed and random conversions checked by a local predictor.
`timescale 1ns / 100ps

module radix_converter_tb;
    import rc_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 1300;
    localparam int MAX_REPORTS   = 30;
    localparam int HOLD_CYCLES   = 3000;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS   = 27;

    // Target digit glyphs, leftmost character in the top byte
    localparam logic [8*36-1:0] GLYPHS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    // Idle mixes
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SRC  = 1;
    localparam int IDLE_DST  = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic [ERR_W-1:0]  err;
    } out_digit_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    rc_in_if  src_if();
    rc_out_if dst_if();

    radix_converter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src       (src_if),
        .dst       (dst_if)
    );

    // Shadow copy of the base registers
    logic [SB_W-1:0] src_base_reg = SB_RESET;
    logic [TB_W-1:0] tgt_base_reg = TB_RESET;

    // Target digits still owed by the block, oldest first
    out_digit_t expected_digits[$];

    int unsigned fail_count    = 0;
    int unsigned items_sent    = 0;
    int unsigned digits_seen   = 0;
    int unsigned zero_items    = 0;
    int unsigned bad_items     = 0;
    int unsigned phases_run    = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned dst_stall_pct = 0;
    int unsigned dst_hold_req  = 0;
    int unsigned hold_left     = 0;
    int unsigned idle_cycles   = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Effective source radix after clamping
    function automatic int unsigned eff_src_base();
        if (src_base_reg < SB_MIN)
            return 32'(SB_MIN);
        if (src_base_reg > SB_MAX)
            return 32'(SB_MAX);
        return 32'(src_base_reg);
    endfunction

    // Expected digits for one accepted number
    task automatic predict_conversion(input logic [SRC_W-1:0] num);
        int unsigned     sb;
        int unsigned     tb;
        int unsigned     rest;
        int unsigned     pos;
        int unsigned     d;
        int unsigned     val;
        longint unsigned acc;
        longint unsigned weight;
        int unsigned     tdig[$];
        out_digit_t      item;

        sb = eff_src_base();
        if (tgt_base_reg < TB_MIN)
            tb = 32'(TB_MIN);
        else if (tgt_base_reg > TB_MAX)
            tb = 32'(TB_MAX);
        else
            tb = 32'(tgt_base_reg);

        item.ch   = '0;
        item.last = 1'b1;
        if (num == '0) begin
            item.err = ERR_ZERO;
            expected_digits.push_back(item);
            zero_items++;
            return;
        end

        // Weight decimal positions by powers of the source radix
        rest   = 32'(num);
        acc    = 0;
        weight = 1;
        for (pos = 0; rest != 0; pos++) begin
            d = rest % 10;
            if (pos >= SRC_DIGITS_DEF || d >= sb) begin
                item.err = ERR_DIGIT;
                expected_digits.push_back(item);
                bad_items++;
                return;
            end
            acc    += d * weight;
            weight *= sb;
            rest   /= 10;
        end

        // 30-bit value never needs more than 30 target digits
        val = 32'(acc & 64'h3FFF_FFFF);
        while (val != 0) begin
            tdig.push_front(val % tb);
            val /= tb;
        end
        foreach (tdig[k]) begin
            item.ch   = GLYPHS[8 * (35 - tdig[k]) +: CHAR_W];
            item.last = (k == tdig.size() - 1);
            item.err  = ERR_OK;
            expected_digits.push_back(item);
        end
    endtask

    // Offer one number, optionally after an idle gap, and wait for the transaction
    task automatic send_number(input logic [SRC_W-1:0] num);
        int unsigned gap;

        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap != 0) begin
            src_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_if.valid      <= 1'b1;
        src_if.src_number <= num;
        do
            @(posedge clk);
        while (!src_if.ready);
        predict_conversion(num);
        items_sent++;
    endtask

    // Stop offering and wait until every owed digit has come back
    task automatic wait_drain(input int unsigned settle);
        src_if.valid <= 1'b0;
        while (expected_digits.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write both base registers back to back; block must be idle
    task automatic set_bases(input logic [CFG_W-1:0] sb_word, input logic [CFG_W-1:0] tb_word);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SOURCE_BASE;
        cfg_data  <= sb_word;
        @(posedge clk);
        src_base_reg = sb_word[SB_W-1:0];
        cfg_index <= REG_TARGET_BASE;
        cfg_data  <= tb_word;
        @(posedge clk);
        tgt_base_reg = tb_word;
        cfg_we <= 1'b0;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            IDLE_SRC:  begin src_idle_pct = 54; dst_stall_pct = 0;  end
            IDLE_DST:  begin src_idle_pct = 0;  dst_stall_pct = 54; end
            IDLE_BOTH: begin src_idle_pct = 18; dst_stall_pct = 18; end
            default:   begin src_idle_pct = 0;  dst_stall_pct = 0;  end
        endcase
    endtask

    // Random number whose every decimal position is a legal digit
    function automatic logic [SRC_W-1:0] well_formed_number(input int unsigned sb);
        int unsigned      ndig;
        int unsigned      scale;
        logic [SRC_W-1:0] num;

        ndig  = $urandom_range(1, SRC_DIGITS_DEF);
        num   = '0;
        scale = 1;
        repeat (ndig) begin
            num   = SRC_W'(num + $urandom_range(0, sb - 1) * scale);
            scale *= 10;
        end
        return num;
    endfunction

    // Legal number with one position spoiled, or a tenth position for radix 10
    function automatic logic [SRC_W-1:0] bad_digit_number(input int unsigned sb);
        int unsigned      pos;
        int unsigned      scale;
        int unsigned      old_d;
        logic [SRC_W-1:0] num;

        if (sb >= 10)
            return SRC_W'(1000000000 + ($urandom % 73741824));
        num   = well_formed_number(sb);
        pos   = $urandom_range(0, SRC_DIGITS_DEF - 1);
        scale = 1;
        repeat (pos) scale *= 10;
        old_d = (num / scale) % 10;
        return SRC_W'(num - old_d * scale + $urandom_range(sb, 9) * scale);
    endfunction

    // Source radix word: extremes, clamped values and noise in the unused bits
    function automatic logic [CFG_W-1:0] pick_src_word();
        int unsigned r;
        int unsigned v;

        r = $urandom_range(0, 9);
        if (r == 0)
            v = 32'(SB_MIN);
        else if (r == 1)
            v = 32'(SB_MAX);
        else if (r == 2) begin
            v = $urandom_range(0, 6);
            if (v >= 2)
                v += 9;
        end else
            v = $urandom_range(SB_MIN, SB_MAX);
        return {2'($urandom), 4'(v)};
    endfunction

    function automatic logic [CFG_W-1:0] pick_tgt_word();
        int unsigned r;
        int unsigned v;

        r = $urandom_range(0, 9);
        if (r == 0)
            v = 32'(TB_MIN);
        else if (r == 1)
            v = 32'(TB_MAX);
        else if (r == 2) begin
            v = $urandom_range(0, 28);
            if (v >= 2)
                v += 35;
        end else
            v = $urandom_range(TB_MIN, TB_MAX);
        return 6'(v);
    endfunction

    function automatic void report_mismatch(input string field, input logic [CHAR_W-1:0] want,
                                            input logic [CHAR_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    // Receiver: random stalls plus an occasional long hold-off
    always @(posedge clk) begin
        if (dst_hold_req != 0) begin
            hold_left    = dst_hold_req;
            dst_hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            dst_if.ready <= 1'b0;
        end else begin
            dst_if.ready <= ($urandom_range(0, 99) >= dst_stall_pct);
        end
    end

    // Compare each output transaction with the oldest owed digit
    always @(posedge clk) begin
        out_digit_t want;

        if (rst_n && dst_if.valid && dst_if.ready) begin
            digits_seen++;
            if (expected_digits.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t ns: unexpected digit, expected none, actual %0h last %0b err %0d",
                             $time, dst_if.digit_char, dst_if.last, dst_if.error);
            end else begin
                want = expected_digits.pop_front();
                if (dst_if.digit_char !== want.ch)
                    report_mismatch("digit_char", want.ch, dst_if.digit_char);
                if (dst_if.last !== want.last)
                    report_mismatch("last", 7'(want.last), 7'(dst_if.last));
                if (dst_if.error !== want.err)
                    report_mismatch("error", 7'(want.err), 7'(dst_if.error));
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk) begin
        if ((src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("radix_converter_tb: FAIL");
            $finish;
        end
    end

    // Field extremes, error cases and clamped bases
    task automatic test_directed_edges();
        set_idle(IDLE_NONE);
        // reset bases: decimal in, binary out
        send_number(30'd0);
        send_number(30'd1);
        send_number(30'd999999999);
        send_number(30'd1000000000);
        send_number(30'h3FFF_FFFF);
        wait_drain(4);
        set_bases(6'd2, 6'd36);
        send_number(30'd111111111);
        send_number(30'd2);
        send_number(30'd101010101);
        send_number(30'd100000000);
        wait_drain(4);
        set_bases(6'd10, 6'd36);
        send_number(30'd999999999);
        send_number(30'd35);
        send_number(30'd36);
        wait_drain(4);
        // below-range bases clamp to 2
        set_bases(6'd0, 6'd0);
        send_number(30'd11);
        send_number(30'd12);
        wait_drain(4);
        // above-range bases clamp to 10 and 36
        set_bases(6'd15, 6'd63);
        send_number(30'd9);
        send_number(30'd123456789);
        wait_drain(4);
        set_bases(6'd1, 6'd37);
        send_number(30'd110);
        wait_drain(4);
        set_bases(6'd9, 6'd1);
        send_number(30'd888888888);
        send_number(30'd19);
        wait_drain(4);
    endtask

    // Receiver held off while the sender keeps offering, then a full drain and a short run with both sides idling
    task automatic test_backpressure();
        set_idle(IDLE_NONE);
        set_bases(6'd10, 6'd2);
        dst_hold_req = HOLD_CYCLES;
        repeat (6) send_number(well_formed_number(10));
        wait_drain(4);
        set_idle(IDLE_BOTH);
        repeat (4) send_number(well_formed_number(10));
        wait_drain(4);
    endtask

    // Random base settings, mostly legal numbers with some noise
    task automatic test_random_conversions();
        int unsigned      phase;
        int unsigned      n;
        int unsigned      pick;
        int unsigned      sb;
        logic [SRC_W-1:0] num;

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_idle(phase % 4);
            set_bases(pick_src_word(), pick_tgt_word());
            sb = eff_src_base();
            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    num = well_formed_number(sb);
                else if (pick < 85)
                    num = bad_digit_number(sb);
                else if (pick < 92)
                    num = 30'($urandom);
                else if (pick < 96)
                    num = '0;
                else
                    num = 30'($urandom_range(1000000000, 30'h3FFF_FFFF));
                send_number(num);
            end
            wait_drain(4);
            phases_run++;
        end
    endtask

    initial begin
        src_if.valid      = 1'b0;
        src_if.src_number = '0;
        dst_if.ready      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_backpressure();
        test_random_conversions();
        wait_drain(SETTLE_CYCLES);

        $display("Run covered %0d numbers (%0d zero, %0d bad digit) and %0d output digits",
                 items_sent, zero_items, bad_items, digits_seen);
        $display("over clamped and extreme bases, %0d random base settings, four idle mixes",
                 phases_run);
        if (fail_count == 0)
            $display("radix_converter_tb: PASS");
        else
            $display("radix_converter_tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rc_pkg.sv
rtl/core/rc_if.sv
rtl/core/radix_converter.sv
tb/radix_converter_tb.sv
